/* rtl/core/kruskal_edge_filter_defines.svh */
// Assertion macros used by the checker file.
`ifndef KRUSKAL_EDGE_FILTER_DEFINES_SVH
`define KRUSKAL_EDGE_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define KEF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define KEF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/kef_pkg.sv */
package kef_pkg;

    // Graph size and field widths
    localparam int MAX_VERTICES  = 64;
    localparam int WEIGHT_BITS   = 16;
    localparam int VID_BITS      = $clog2(MAX_VERTICES);
    localparam int VC_BITS       = VID_BITS + 1;
    localparam int CNT_BITS      = 6;

    // Cell row organization: groups of cells chained inside, registered at the tail
    localparam int GROUP_BITS    = 3;
    localparam int GROUP_SIZE    = 1 << GROUP_BITS;
    localparam int NUM_GROUPS    = MAX_VERTICES / GROUP_SIZE;
    localparam int GRP_IDX_BITS  = VID_BITS - GROUP_BITS;

    // Register port
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;
    localparam logic [REG_IDX_BITS-1:0] REG_VERTEX_COUNT = '0;

    // Result status codes
    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_SAME     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_END      = 2'd3
    } status_t;

    typedef struct packed {
        logic                   first;
        logic [VID_BITS-1:0]    from_vertex;
        logic [VID_BITS-1:0]    to_vertex;
        logic [WEIGHT_BITS-1:0] weight;
    } kef_in_t;

    typedef struct packed {
        logic                   accepted;
        status_t                status;
        logic [CNT_BITS-1:0]    tree_index;
        logic [VID_BITS-1:0]    edge_from;
        logic [VID_BITS-1:0]    edge_to;
        logic [WEIGHT_BITS-1:0] edge_weight;
    } kef_out_t;

    // Command broadcast from the controller to every cell
    typedef struct packed {
        logic                restart;
        logic                relabel;
        logic [VID_BITS-1:0] old_label;
        logic [VID_BITS-1:0] new_label;
        logic [VID_BITS-1:0] u;
        logic [VID_BITS-1:0] v;
    } kef_cmd_t;

    // Lookup value handed from cell to cell
    typedef struct packed {
        logic [VID_BITS-1:0] lu;
        logic [VID_BITS-1:0] lv;
    } kef_look_t;

endpackage

/* rtl/core/kef_if.sv */
// Edge input channel
interface kef_in_if;
    logic             valid;
    logic             ready;
    kef_pkg::kef_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result output channel
interface kef_out_if;
    logic              valid;
    logic              ready;
    kef_pkg::kef_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/kruskal_edge_filter.sv */
// A result is registered after its edge passes S_LOOK and S_DECIDE (longer if the
// output is stalled). A new edge is taken in S_IDLE or as the last leaves S_DECIDE,
// set by the registered row lookup followed by the relabel broadcast to all cells.
// Reset: rst_n (async, active low) restores identity labels, tree count zero,
// vertex_count 64, no pending result. No clearing pass is needed.
module kruskal_edge_filter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kef_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [kef_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [kef_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready,
    kef_in_if.sink                            edge_in,
    kef_out_if.source                         result_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_DECIDE
    } state_t;

    state_t                       state_reg, state_next;
    kef_pkg::kef_in_t             item_reg;
    logic [kef_pkg::CNT_BITS-1:0] count_reg;
    logic                         out_valid_reg;
    kef_pkg::kef_out_t            out_data_reg;

    logic [kef_pkg::VC_BITS-1:0]  vertex_count;
    logic [kef_pkg::VC_BITS-1:0]  n_sat;
    kef_pkg::kef_look_t           grp_look [kef_pkg::NUM_GROUPS];
    kef_pkg::kef_look_t           look;
    kef_pkg::kef_cmd_t            cmd;
    kef_pkg::status_t             status;
    logic                         join_tree;
    logic                         decide_fire;
    logic                         in_xfer;

    kef_apb u_apb (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .vertex_count (vertex_count)
    );

    // Handshakes
    assign decide_fire   = (state_reg == S_DECIDE) && (!out_valid_reg || result_out.ready);
    assign edge_in.ready = (state_reg == S_IDLE) || decide_fire;
    assign in_xfer       = edge_in.valid && edge_in.ready;

    // Broadcast to the cell row
    always_comb
    begin
        cmd.restart   = in_xfer && edge_in.data.first;
        cmd.relabel   = decide_fire && join_tree;
        cmd.old_label = look.lv;
        cmd.new_label = look.lu;
        cmd.u         = item_reg.from_vertex;
        cmd.v         = item_reg.to_vertex;
    end

    for (genvar g = 0; g < kef_pkg::NUM_GROUPS; g++)
    begin : g_grp
        kef_group u_group (
            .clk     (clk),
            .rst_n   (rst_n),
            .grp_idx (kef_pkg::GRP_IDX_BITS'(g)),
            .cmd     (cmd),
            .look    (grp_look[g])
        );
    end

    // Merge the registered group results
    always_comb
    begin
        look = '0;
        for (int g = 0; g < kef_pkg::NUM_GROUPS; g++)
        begin
            look.lu = look.lu | grp_look[g].lu;
            look.lv = look.lv | grp_look[g].lv;
        end
    end

    // Classify the edge: end marker, then range, then labels
    always_comb
    begin
        n_sat = (vertex_count > kef_pkg::VC_BITS'(kef_pkg::MAX_VERTICES)) ?
                kef_pkg::VC_BITS'(kef_pkg::MAX_VERTICES) : vertex_count;
        priority if (item_reg.weight == '0)
        begin
            status = kef_pkg::ST_END;
        end
        else if ((kef_pkg::VC_BITS'(item_reg.from_vertex) >= n_sat) ||
                 (kef_pkg::VC_BITS'(item_reg.to_vertex) >= n_sat))
        begin
            status = kef_pkg::ST_RANGE;
        end
        else if (look.lu == look.lv)
        begin
            status = kef_pkg::ST_SAME;
        end
        else
        begin
            status = kef_pkg::ST_ACCEPTED;
        end
        join_tree = (status == kef_pkg::ST_ACCEPTED);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (decide_fire)
                begin
                    state_next = in_xfer ? S_LOOK : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (in_xfer)
            begin
                item_reg <= edge_in.data;
            end

            // A new graph overrides the increment of the edge finishing now
            if (in_xfer && edge_in.data.first)
            begin
                count_reg <= '0;
            end
            else if (decide_fire && join_tree)
            begin
                count_reg <= count_reg + 1'b1;
            end

            // Output register
            if (decide_fire)
            begin
                out_valid_reg            <= 1'b1;
                out_data_reg.accepted    <= join_tree;
                out_data_reg.status      <= status;
                out_data_reg.tree_index  <= join_tree ? count_reg : '0;
                out_data_reg.edge_from   <= item_reg.from_vertex;
                out_data_reg.edge_to     <= item_reg.to_vertex;
                out_data_reg.edge_weight <= item_reg.weight;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_out.valid = out_valid_reg;
    assign result_out.data  = out_data_reg;

endmodule

/* rtl/core/kef_cell.sv */
module kef_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [kef_pkg::VID_BITS-1:0] cell_idx,
    input  kef_pkg::kef_cmd_t            cmd,
    input  kef_pkg::kef_look_t           chain_in,
    output kef_pkg::kef_look_t           chain_out
);

    logic                         written_reg;
    logic [kef_pkg::VID_BITS-1:0] label_reg;
    logic [kef_pkg::VID_BITS-1:0] label;
    logic                         hit;

    // Unwritten cell reads as its own index
    assign label = written_reg ? label_reg : cell_idx;
    assign hit   = cmd.relabel && !cmd.restart && (label == cmd.old_label);

    // Pass the lookup on, adding our label where the index matches
    assign chain_out.lu = chain_in.lu | ((cell_idx == cmd.u) ? label : '0);
    assign chain_out.lv = chain_in.lv | ((cell_idx == cmd.v) ? label : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= 1'b0;
        end
        else if (cmd.restart)
        begin
            written_reg <= 1'b0;
        end
        else if (hit)
        begin
            written_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            label_reg <= cmd.new_label;
        end
    end

endmodule

/* rtl/core/kef_group.sv */
module kef_group (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [kef_pkg::GRP_IDX_BITS-1:0] grp_idx,
    input  kef_pkg::kef_cmd_t                cmd,
    output kef_pkg::kef_look_t               look
);

    kef_pkg::kef_look_t chain [kef_pkg::GROUP_SIZE+1];
    kef_pkg::kef_look_t look_reg;

    assign chain[0] = '0;

    // Cells in a row, each handing the lookup to its neighbor
    for (genvar k = 0; k < kef_pkg::GROUP_SIZE; k++)
    begin : g_cell
        kef_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  ({grp_idx, kef_pkg::GROUP_BITS'(k)}),
            .cmd       (cmd),
            .chain_in  (chain[k]),
            .chain_out (chain[k+1])
        );
    end

    // Register the tail of the row
    always_ff @(posedge clk)
    begin
        look_reg <= chain[kef_pkg::GROUP_SIZE];
    end

    assign look = look_reg;

endmodule

/* rtl/core/kef_apb.sv */
module kef_apb (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kef_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [kef_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [kef_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready,
    output logic [kef_pkg::VC_BITS-1:0]       vertex_count
);

    logic [kef_pkg::VC_BITS-1:0]      vertex_count_reg;
    logic [kef_pkg::REG_IDX_BITS-1:0] reg_idx;
    logic                             wr_xfer;

    assign reg_idx = paddr[kef_pkg::APB_ADDR_BITS-1:2];
    assign pready  = 1'b1;
    assign wr_xfer = psel && penable && pwrite;

    // Vertex count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= kef_pkg::VC_BITS'(kef_pkg::MAX_VERTICES);
        end
        else if (wr_xfer && (reg_idx == kef_pkg::REG_VERTEX_COUNT))
        begin
            vertex_count_reg <= pwdata[kef_pkg::VC_BITS-1:0];
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (reg_idx == kef_pkg::REG_VERTEX_COUNT)
        begin
            prdata = kef_pkg::APB_DATA_BITS'(vertex_count_reg);
        end
    end

    assign vertex_count = vertex_count_reg;

endmodule

/* rtl/core/kef_checker.sv */
`include "kruskal_edge_filter_defines.svh"

module kef_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input kef_pkg::kef_out_t out_data
);

    // Accepted flag agrees with status
    `KEF_ASSERT_NOW(a_accept_status, out_valid, out_data.accepted == (out_data.status == kef_pkg::ST_ACCEPTED), "accepted flag disagrees with status")

    // Rejected edges carry tree index zero
    `KEF_ASSERT_NOW(a_index_zero, out_valid && !out_data.accepted, out_data.tree_index == '0, "tree index set on rejected edge")

    // End status exactly when the echoed weight is zero
    `KEF_ASSERT_NOW(a_end_weight, out_valid, (out_data.status == kef_pkg::ST_END) == (out_data.edge_weight == '0), "end status does not match zero weight")

    // A stalled result holds
    `KEF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind kruskal_edge_filter kef_checker u_kef_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_data  (result_out.data)
);

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam logic [kef_pkg::APB_ADDR_BITS-1:0] VC_ADDR = {kef_pkg::REG_VERTEX_COUNT, 2'b00};
    localparam int HOLD_LEN = 400;

    // Clock, reset, register port
    logic                              clk     = 1'b0;
    logic                              rst_n   = 1'b0;
    logic                              psel    = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite  = 1'b0;
    logic [kef_pkg::APB_ADDR_BITS-1:0] paddr   = '0;
    logic [kef_pkg::APB_DATA_BITS-1:0] pwdata  = '0;
    logic [kef_pkg::APB_DATA_BITS-1:0] prdata;
    logic                              pready;

    // Stream channels, driven from local registers
    kef_in_if  edge_if();
    kef_out_if result_if();

    logic             send_valid = 1'b0;
    kef_pkg::kef_in_t send_data  = '0;
    logic             take_ready = 1'b0;

    assign edge_if.valid   = send_valid;
    assign edge_if.data    = send_data;
    assign result_if.ready = take_ready;

    kruskal_edge_filter u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .edge_in    (edge_if),
        .result_out (result_if)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Model of the label store and tree counter
    logic [kef_pkg::VID_BITS-1:0] graph_label [kef_pkg::MAX_VERTICES];
    logic [kef_pkg::CNT_BITS-1:0] tree_count;
    logic [kef_pkg::VC_BITS-1:0]  vertex_limit;

    // Bookkeeping
    kef_pkg::kef_in_t  edge_backlog[$];
    kef_pkg::kef_out_t expected_verdicts[$];
    kef_pkg::kef_in_t  send_next;
    logic     edge_loaded  = 1'b0;
    logic     result_taken = 1'b0;
    logic     hold_request = 1'b0;
    int       send_gap     = 0;
    int       send_calm    = 0;
    int       take_stall   = 0;
    int       take_calm    = 0;
    int       hold_cycles  = 0;
    int       errors       = 0;
    int       edges_queued = 0;
    int       edges_sent   = 0;
    int       settings_run = 0;
    int       deepest_index = 0;
    int       status_tally [4];

    function automatic void restart_labels();
        for (int i = 0; i < kef_pkg::MAX_VERTICES; i++)
            graph_label[i] = kef_pkg::VID_BITS'(i);
        tree_count = '0;
    endfunction

    // Expected verdict for one edge; updates the label model
    function automatic kef_pkg::kef_out_t filter_edge(input kef_pkg::kef_in_t e);
        kef_pkg::kef_out_t            r;
        int                           n;
        logic [kef_pkg::VID_BITS-1:0] old_lab;
        logic [kef_pkg::VID_BITS-1:0] new_lab;
        n = (vertex_limit > kef_pkg::MAX_VERTICES) ? kef_pkg::MAX_VERTICES
                                                   : int'(vertex_limit);
        if (e.first)
            restart_labels();
        r.accepted    = 1'b0;
        r.tree_index  = '0;
        r.edge_from   = e.from_vertex;
        r.edge_to     = e.to_vertex;
        r.edge_weight = e.weight;
        // end marker wins over range, range wins over labels
        if (e.weight == '0)
            r.status = kef_pkg::ST_END;
        else if (int'(e.from_vertex) >= n || int'(e.to_vertex) >= n)
            r.status = kef_pkg::ST_RANGE;
        else if (graph_label[e.from_vertex] == graph_label[e.to_vertex])
            r.status = kef_pkg::ST_SAME;
        else
        begin
            old_lab      = graph_label[e.to_vertex];
            new_lab      = graph_label[e.from_vertex];
            r.accepted   = 1'b1;
            r.status     = kef_pkg::ST_ACCEPTED;
            r.tree_index = tree_count;
            tree_count   = tree_count + 1'b1;
            for (int j = 0; j < kef_pkg::MAX_VERTICES; j++)
                if (graph_label[j] == old_lab)
                    graph_label[j] = new_lab;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic void offer_edge(input int f, input int a, input int b, input int w);
        kef_pkg::kef_in_t e;
        e.first       = f[0];
        e.from_vertex = kef_pkg::VID_BITS'(a);
        e.to_vertex   = kef_pkg::VID_BITS'(b);
        e.weight      = kef_pkg::WEIGHT_BITS'(w);
        edge_backlog.push_back(e);
        edges_queued++;
    endfunction

    // Driver: one edge at a time from the backlog, random gap before each
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!edge_loaded && edge_backlog.size() != 0)
            begin
                send_next   = edge_backlog.pop_front();
                edge_loaded = 1'b1;
                if (send_calm > 0)
                begin
                    send_gap = 0;
                    send_calm--;
                end
                else
                begin
                    send_gap = $urandom_range(0, 17);
                    if ($urandom_range(0, 15) == 0)
                        send_calm = $urandom_range(20, 60);
                end
            end
            if (edge_loaded && send_gap == 0)
            begin
                send_valid <= 1'b1;
                send_data  <= send_next;
            end
            else
            begin
                if (send_gap > 0)
                    send_gap--;
                send_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall after each transfer, plus the long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_taken)
            begin
                result_taken = 1'b0;
                if (take_calm > 0)
                begin
                    take_stall = 0;
                    take_calm--;
                end
                else
                begin
                    take_stall = $urandom_range(0, 17);
                    if ($urandom_range(0, 15) == 0)
                        take_calm = $urandom_range(20, 60);
                end
            end
            if (take_stall > 0)
            begin
                take_stall--;
                take_ready <= 1'b0;
            end
            else
                take_ready <= (hold_cycles == 0);
        end
    end

    // Hold-off countdown
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_cycles  = HOLD_LEN;
        end
        else if (hold_cycles > 0)
            hold_cycles--;
    end

    // Monitor: check results first, then record the edge transfer
    always @(posedge clk)
    begin : monitor
        kef_pkg::kef_out_t want;
        if (rst_n)
        begin
            if (result_if.valid && take_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("result with no edge outstanding: status %0d from %0d to %0d",
                           result_if.data.status, result_if.data.edge_from,
                           result_if.data.edge_to);
                    errors++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    check_field("accepted", want.accepted, result_if.data.accepted);
                    check_field("status", want.status, result_if.data.status);
                    check_field("tree_index", want.tree_index, result_if.data.tree_index);
                    check_field("edge_from", want.edge_from, result_if.data.edge_from);
                    check_field("edge_to", want.edge_to, result_if.data.edge_to);
                    check_field("edge_weight", want.edge_weight, result_if.data.edge_weight);
                    status_tally[want.status]++;
                    if (want.accepted && int'(want.tree_index) > deepest_index)
                        deepest_index = want.tree_index;
                end
                result_taken = 1'b1;
            end
            if (send_valid && edge_if.ready)
            begin
                expected_verdicts.push_back(filter_edge(send_data));
                edge_loaded = 1'b0;
                edges_sent++;
            end
        end
    end

    task automatic wait_idle();
        while (edge_backlog.size() != 0 || edge_loaded || expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Register write followed by a read-back
    task automatic set_vertex_count(input logic [kef_pkg::APB_DATA_BITS-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= VC_ADDR;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        vertex_limit = value[kef_pkg::VC_BITS-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field("vertex_count", kef_pkg::APB_DATA_BITS'(vertex_limit), prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_run++;
    endtask

    // Fully random edges, including end markers and stray restarts
    task automatic queue_noise(input int count);
        for (int k = 0; k < count; k++)
            offer_edge($urandom_range(0, 1), $urandom_range(0, 63), $urandom_range(0, 63),
                       ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 65535));
    endtask

    // One sorted graph: optional spanning tree plus random edges, shuffled
    task automatic queue_graph(input int n, input bit spanning);
        int ends_a[$];
        int ends_b[$];
        int order [kef_pkg::MAX_VERTICES];
        int extra;
        int j;
        int t;
        int w;
        for (int k = 0; k < n; k++)
            order[k] = k;
        for (int k = n - 1; k > 0; k--)
        begin
            j        = $urandom_range(0, k);
            t        = order[k];
            order[k] = order[j];
            order[j] = t;
        end
        if (spanning)
            for (int k = 1; k < n; k++)
            begin
                j = $urandom_range(0, k - 1);
                if ($urandom_range(0, 1))
                begin
                    ends_a.push_back(order[k]);
                    ends_b.push_back(order[j]);
                end
                else
                begin
                    ends_a.push_back(order[j]);
                    ends_b.push_back(order[k]);
                end
            end
        extra = $urandom_range(spanning ? 0 : 1, spanning ? n : 2 * n + 4);
        for (int k = 0; k < extra; k++)
        begin
            ends_a.push_back(($urandom_range(0, 24) == 0) ? $urandom_range(0, 63)
                                                          : $urandom_range(0, n - 1));
            ends_b.push_back(($urandom_range(0, 24) == 0) ? $urandom_range(0, 63)
                                                          : $urandom_range(0, n - 1));
        end
        for (int k = ends_a.size() - 1; k > 0; k--)
        begin
            j         = $urandom_range(0, k);
            t         = ends_a[k];
            ends_a[k] = ends_a[j];
            ends_a[j] = t;
            t         = ends_b[k];
            ends_b[k] = ends_b[j];
            ends_b[j] = t;
        end
        // ascending weights, restart on the first edge
        w = $urandom_range(1, 60000);
        for (int k = 0; k < ends_a.size(); k++)
        begin
            offer_edge(k == 0, ends_a[k], ends_b[k], w);
            w = w + $urandom_range(0, 120);
            if (w > 65535)
                w = 65535;
        end
        if ($urandom_range(0, 3) != 0)
            offer_edge(0, $urandom_range(0, 63), $urandom_range(0, 63), 0);
    endtask

    // Stimulus
    initial
    begin : stimulus
        int vc_plan [$];
        int vc;
        int n;
        int phase;
        int phase_start;
        int directed_total;
        logic [kef_pkg::APB_DATA_BITS-1:0] value;
        vc_plan = '{64, 64, 1, 2, 63, 127, 40, 0, 64, 17};
        vertex_limit = kef_pkg::VC_BITS'(kef_pkg::MAX_VERTICES);
        restart_labels();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset vertex count: accepts, cycles, self loop, end markers, extremes
        offer_edge(1, 0, 1, 1);
        offer_edge(0, 1, 2, 2);
        offer_edge(0, 2, 0, 3);
        offer_edge(0, 5, 5, 4);
        offer_edge(0, 63, 62, 5);
        offer_edge(0, 0, 63, 6);
        offer_edge(0, 3, 4, 0);
        offer_edge(0, 4, 3, 7);
        offer_edge(0, 63, 63, 65535);
        offer_edge(1, 0, 0, 0);
        offer_edge(0, 62, 63, 65535);
        offer_edge(0, 21, 42, 32768);
        offer_edge(0, 42, 21, 32769);
        wait_idle();

        // Small graph: endpoints out of range, end marker ahead of range
        set_vertex_count(32'd10);
        offer_edge(1, 10, 3, 100);
        offer_edge(0, 3, 10, 101);
        offer_edge(0, 9, 0, 102);
        offer_edge(0, 63, 63, 0);
        offer_edge(0, 0, 9, 103);
        wait_idle();

        // Zero vertices: everything out of range
        set_vertex_count(32'd0);
        offer_edge(1, 0, 0, 1);
        offer_edge(0, 0, 0, 0);
        wait_idle();

        // Oversized count saturates to the full graph
        set_vertex_count(32'hFFFF_FFFF);
        offer_edge(1, 63, 0, 5);
        offer_edge(0, 63, 62, 6);
        offer_edge(0, 0, 62, 7);
        wait_idle();
        directed_total = edges_queued;

        // Random graphs over a series of vertex counts
        phase = 0;
        while (edges_queued - directed_total < 2000)
        begin
            vc = (phase < vc_plan.size()) ? vc_plan[phase] : $urandom_range(0, 127);
            value = $urandom;
            value[kef_pkg::VC_BITS-1:0] = kef_pkg::VC_BITS'(vc);
            set_vertex_count(value);
            n = (vc > kef_pkg::MAX_VERTICES) ? kef_pkg::MAX_VERTICES : vc;
            if (phase == 1)
                hold_request = 1'b1;
            phase_start = edges_queued;
            while (edges_queued - phase_start < ((n == 0) ? 40 : (n <= 2) ? 60 : 200))
            begin
                if (n == 0 || $urandom_range(0, 9) == 0)
                    queue_noise($urandom_range(1, 6));
                else
                    queue_graph(n, $urandom_range(0, 2) != 0);
            end
            wait_idle();
            phase++;
        end

        // Drain and report
        repeat (20) @(negedge clk);
        if (expected_verdicts.size() != 0)
        begin
            $error("%0d results never arrived", expected_verdicts.size());
            errors++;
        end
        $display("Sent %0d edges under %0d vertex_count settings, one %0d-cycle output hold",
                 edges_sent, settings_run, HOLD_LEN);
        $display("Joined %0d, same component %0d, out of range %0d, end marker %0d, max index %0d",
                 status_tally[kef_pkg::ST_ACCEPTED], status_tally[kef_pkg::ST_SAME],
                 status_tally[kef_pkg::ST_RANGE], status_tally[kef_pkg::ST_END],
                 deepest_index);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
